@@ design/idbw_pkg.sv @@
package idbw_pkg;

  localparam int unsigned ByteW = 8;

  localparam logic [ByteW-1:0] AddrReset = 8'h78;
  localparam logic [ByteW-1:0] CtrlCmd   = 8'h00;
  localparam logic [ByteW-1:0] CtrlData  = 8'h40;

  localparam logic ReqTick = 1'b0;
  localparam logic ReqSend = 1'b1;

  typedef struct packed {
    logic             req_type;
    logic             is_data;
    logic [ByteW-1:0] payload;
    logic             sda_sample;
  } in_item_t;

  typedef struct packed {
    logic scl_level;
    logic sda_level;
    logic busy_res;
    logic done_res;
    logic nack_seen;
  } out_item_t;

endpackage

@@ design/idbw_in_if.sv @@
interface idbw_in_if;
  logic                     valid;
  logic                     ready;
  logic                     req_type;
  logic                     is_data;
  logic [idbw_pkg::ByteW-1:0] payload;
  logic                     sda_sample;

  modport source (output valid, output req_type, output is_data, output payload,
                  output sda_sample, input ready);
  modport sink (input valid, input req_type, input is_data, input payload,
                input sda_sample, output ready);
endinterface

@@ design/idbw_out_if.sv @@
interface idbw_out_if;
  logic valid;
  logic ready;
  logic scl_level;
  logic sda_level;
  logic busy_res;
  logic done_res;
  logic nack_seen;

  modport source (output valid, output scl_level, output sda_level, output busy_res,
                  output done_res, output nack_seen, input ready);
  modport sink (input valid, input scl_level, input sda_level, input busy_res,
                input done_res, input nack_seen, output ready);
endinterface

@@ design/i2c_display_byte_writer.sv @@
// The result of a transaction is registered and presented in the cycle after it is accepted.
// Throughput: one transaction per cycle while the output is not stalled; the bus state update
// is a single step between the input handshake and the output register.
// Reset (rst, synchronous, active high): bus idle, both lines released,
// address register back to 0x78, output register empty.
module i2c_display_byte_writer (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_wr_en,
  input  logic [7:0]       cfg_wr_data,
  idbw_in_if.sink          in_ch,
  idbw_out_if.source       out_ch
);

  localparam logic [2:0] PH_IDLE    = 3'd0;
  localparam logic [2:0] PH_START   = 3'd1;
  localparam logic [2:0] PH_BITS    = 3'd2;
  localparam logic [2:0] PH_ACK     = 3'd3;
  localparam logic [2:0] PH_STOP    = 3'd4;
  localparam logic [2:0] PH_ACKFALL = 3'd5;

  logic [idbw_pkg::ByteW-1:0] slave_addr;

  logic [2:0] phase, phase_next;
  logic [1:0] tick_step, tick_step_next;
  logic [2:0] bit_count, bit_count_next;
  logic [1:0] byte_slot, byte_slot_next;
  logic [idbw_pkg::ByteW-1:0] shift_byte, shift_byte_next;
  logic [idbw_pkg::ByteW-1:0] held_payload, held_payload_next;
  logic held_is_data, held_is_data_next;
  logic scl, scl_next;
  logic sda, sda_next;
  logic done, nack;

  idbw_pkg::in_item_t  item;
  idbw_pkg::out_item_t res, res_next;
  logic                res_valid;
  logic                accept;

  assign item = {in_ch.req_type, in_ch.is_data, in_ch.payload, in_ch.sda_sample};

  assign in_ch.ready = !res_valid || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  always_comb begin
    phase_next        = phase;
    tick_step_next    = tick_step;
    bit_count_next    = bit_count;
    byte_slot_next    = byte_slot;
    shift_byte_next   = shift_byte;
    held_payload_next = held_payload;
    held_is_data_next = held_is_data;
    scl_next          = scl;
    sda_next          = sda;
    done              = 1'b0;
    nack              = 1'b0;

    if (item.req_type == idbw_pkg::ReqSend) begin
      if (phase == PH_IDLE) begin
        held_payload_next = item.payload;
        held_is_data_next = item.is_data;
        phase_next        = PH_START;
        tick_step_next    = 2'd0;
        bit_count_next    = 3'd0;
        byte_slot_next    = 2'd0;
      end
    end else begin
      unique case (phase)
        PH_IDLE: begin
        end
        PH_START: begin
          unique case (tick_step)
            2'd0: begin
              scl_next = 1'b1;
              sda_next = 1'b1;
              tick_step_next = 2'd1;
            end
            2'd1: begin
              sda_next = 1'b0;
              tick_step_next = 2'd2;
            end
            2'd2: begin
              scl_next        = 1'b0;
              byte_slot_next  = 2'd0;
              shift_byte_next = slave_addr;
              bit_count_next  = 3'd0;
              phase_next      = PH_BITS;
              tick_step_next  = 2'd0;
            end
            default: begin
              phase_next = PH_IDLE;
              tick_step_next = 2'd0;
              bit_count_next = 3'd0;
              byte_slot_next = 2'd0;
              scl_next = 1'b1;
              sda_next = 1'b1;
            end
          endcase
        end
        PH_BITS: begin
          unique case (tick_step)
            2'd0: begin
              scl_next = 1'b0;
              tick_step_next = 2'd1;
            end
            2'd1: begin
              sda_next        = shift_byte[idbw_pkg::ByteW-1];
              shift_byte_next = {shift_byte[idbw_pkg::ByteW-2:0], 1'b0};
              tick_step_next  = 2'd2;
            end
            2'd2: begin
              scl_next = 1'b1;
              if (bit_count == 3'd7) begin
                bit_count_next = 3'd0;
                phase_next     = PH_ACK;
              end else begin
                bit_count_next = bit_count + 3'd1;
              end
              tick_step_next = 2'd0;
            end
            default: begin
              phase_next = PH_IDLE;
              tick_step_next = 2'd0;
              bit_count_next = 3'd0;
              byte_slot_next = 2'd0;
              scl_next = 1'b1;
              sda_next = 1'b1;
            end
          endcase
        end
        PH_ACK: begin
          unique case (tick_step)
            2'd0: begin
              scl_next = 1'b0;
              tick_step_next = 2'd1;
            end
            2'd1: begin
              sda_next = 1'b1;
              tick_step_next = 2'd2;
            end
            2'd2: begin
              scl_next = 1'b1;
              if (item.sda_sample) begin
                nack = 1'b1;
                tick_step_next = 2'd3;
              end else begin
                phase_next = PH_ACKFALL;
                tick_step_next = 2'd0;
              end
            end
            default: begin
              scl_next = 1'b0;
              tick_step_next = 2'd1;
            end
          endcase
        end
        PH_ACKFALL: begin
          scl_next = 1'b0;
          priority if (byte_slot == 2'd0) begin
            byte_slot_next  = 2'd1;
            shift_byte_next = held_is_data ? idbw_pkg::CtrlData : idbw_pkg::CtrlCmd;
            bit_count_next  = 3'd0;
            phase_next      = PH_BITS;
            tick_step_next  = 2'd0;
          end else if (byte_slot == 2'd1) begin
            byte_slot_next  = 2'd2;
            shift_byte_next = held_payload;
            bit_count_next  = 3'd0;
            phase_next      = PH_BITS;
            tick_step_next  = 2'd0;
          end else begin
            phase_next     = PH_STOP;
            tick_step_next = 2'd0;
          end
        end
        PH_STOP: begin
          unique case (tick_step)
            2'd0: begin
              sda_next = 1'b0;
              tick_step_next = 2'd1;
            end
            2'd1: begin
              scl_next = 1'b1;
              tick_step_next = 2'd2;
            end
            2'd2: begin
              done = 1'b1;
              phase_next = PH_IDLE;
              tick_step_next = 2'd0;
              bit_count_next = 3'd0;
              byte_slot_next = 2'd0;
              scl_next = 1'b1;
              sda_next = 1'b1;
            end
            default: begin
              phase_next = PH_IDLE;
              tick_step_next = 2'd0;
              bit_count_next = 3'd0;
              byte_slot_next = 2'd0;
              scl_next = 1'b1;
              sda_next = 1'b1;
            end
          endcase
        end
        default: begin
          phase_next = PH_IDLE;
          tick_step_next = 2'd0;
          bit_count_next = 3'd0;
          byte_slot_next = 2'd0;
          scl_next = 1'b1;
          sda_next = 1'b1;
        end
      endcase
    end

    res_next.scl_level = scl_next;
    res_next.sda_level = sda_next;
    res_next.busy_res  = (phase_next != PH_IDLE);
    res_next.done_res  = done;
    res_next.nack_seen = nack;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slave_addr <= idbw_pkg::AddrReset;
    end else if (cfg_wr_en) begin
      slave_addr <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_IDLE;
      tick_step <= 2'd0;
      bit_count <= 3'd0;
      byte_slot <= 2'd0;
      scl       <= 1'b1;
      sda       <= 1'b1;
      res_valid <= 1'b0;
    end else begin
      if (accept) begin
        phase     <= phase_next;
        tick_step <= tick_step_next;
        bit_count <= bit_count_next;
        byte_slot <= byte_slot_next;
        scl       <= scl_next;
        sda       <= sda_next;
        res_valid <= 1'b1;
      end else if (out_ch.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      shift_byte   <= shift_byte_next;
      held_payload <= held_payload_next;
      held_is_data <= held_is_data_next;
      res          <= res_next;
    end
  end

  assign out_ch.valid     = res_valid;
  assign out_ch.scl_level = res.scl_level;
  assign out_ch.sda_level = res.sda_level;
  assign out_ch.busy_res  = res.busy_res;
  assign out_ch.done_res  = res.done_res;
  assign out_ch.nack_seen = res.nack_seen;

endmodule

@@ sim/i2c_write_checker.sv @@
`timescale 1ns / 100ps
module i2c_write_checker
  import idbw_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data,
  idbw_in_if         in_ch,
  idbw_out_if        out_ch,
  output int         outstanding,
  output int         fail_count
);

  typedef enum logic [2:0] {
    BusIdle    = 3'd0,
    BusStart   = 3'd1,
    BusBits    = 3'd2,
    BusAck     = 3'd3,
    BusStop    = 3'd4,
    BusAckFall = 3'd5
  } bus_phase_t;

  bus_phase_t       phase;
  logic [1:0]       step;
  logic [2:0]       bit_cnt;
  logic [1:0]       slot;
  logic [ByteW-1:0] shifter;
  logic [ByteW-1:0] held_payload;
  logic             held_is_data;
  logic [ByteW-1:0] addr_byte;
  logic             scl;
  logic             sda;

  out_item_t        levels_due[$];

  function automatic void bus_to_idle();
    phase   = BusIdle;
    step    = 2'd0;
    bit_cnt = 3'd0;
    slot    = 2'd0;
    scl     = 1'b1;
    sda     = 1'b1;
  endfunction

  function automatic void load_byte(logic [ByteW-1:0] value);
    shifter = value;
    bit_cnt = 3'd0;
    phase   = BusBits;
    step    = 2'd0;
  endfunction

  function automatic out_item_t advance_bus(in_item_t it);
    out_item_t r;
    logic      done;
    logic      nack;
    done = 1'b0;
    nack = 1'b0;
    if (it.req_type == ReqSend) begin
      if (phase == BusIdle) begin
        held_payload = it.payload;
        held_is_data = it.is_data;
        phase        = BusStart;
        step         = 2'd0;
        bit_cnt      = 3'd0;
        slot         = 2'd0;
      end
    end else begin
      case (phase)
        BusIdle: ;
        BusStart: begin
          if (step == 2'd0) begin
            scl  = 1'b1;
            sda  = 1'b1;
            step = 2'd1;
          end else if (step == 2'd1) begin
            sda  = 1'b0;
            step = 2'd2;
          end else if (step == 2'd2) begin
            scl  = 1'b0;
            slot = 2'd0;
            load_byte(addr_byte);
          end else begin
            bus_to_idle();
          end
        end
        BusBits: begin
          if (step == 2'd0) begin
            scl  = 1'b0;
            step = 2'd1;
          end else if (step == 2'd1) begin
            sda     = shifter[ByteW-1];
            shifter = {shifter[ByteW-2:0], 1'b0};
            step    = 2'd2;
          end else if (step == 2'd2) begin
            scl = 1'b1;
            if (bit_cnt == 3'd7) begin
              bit_cnt = 3'd0;
              phase   = BusAck;
            end else begin
              bit_cnt = bit_cnt + 3'd1;
            end
            step = 2'd0;
          end else begin
            bus_to_idle();
          end
        end
        BusAck: begin
          if (step == 2'd0) begin
            scl  = 1'b0;
            step = 2'd1;
          end else if (step == 2'd1) begin
            sda  = 1'b1;
            step = 2'd2;
          end else if (step == 2'd2) begin
            scl = 1'b1;
            if (it.sda_sample) begin
              nack = 1'b1;
              step = 2'd3;
            end else begin
              phase = BusAckFall;
              step  = 2'd0;
            end
          end else begin
            // nack: clock falls, then the ack clock repeats
            scl  = 1'b0;
            step = 2'd1;
          end
        end
        BusAckFall: begin
          scl = 1'b0;
          if (slot == 2'd0) begin
            slot = 2'd1;
            load_byte(held_is_data ? CtrlData : CtrlCmd);
          end else if (slot == 2'd1) begin
            slot = 2'd2;
            load_byte(held_payload);
          end else begin
            phase = BusStop;
            step  = 2'd0;
          end
        end
        BusStop: begin
          if (step == 2'd0) begin
            sda  = 1'b0;
            step = 2'd1;
          end else if (step == 2'd1) begin
            scl  = 1'b1;
            step = 2'd2;
          end else if (step == 2'd2) begin
            sda  = 1'b1;
            done = 1'b1;
            bus_to_idle();
          end else begin
            bus_to_idle();
          end
        end
        default: bus_to_idle();
      endcase
    end
    r = '{scl_level: scl, sda_level: sda, busy_res: (phase != BusIdle),
          done_res: done, nack_seen: nack};
    return r;
  endfunction

  task automatic report(string msg);
    $display("%0t checker: %s", $time, msg);
    fail_count++;
  endtask

  task automatic compare_field(string name, logic got, logic want);
    if (got !== want)
      report($sformatf("%s mismatch: got %0b expected %0b", name, got, want));
  endtask

  always @(posedge clk) begin
    in_item_t  it;
    out_item_t got;
    out_item_t due;
    if (rst) begin
      addr_byte    = AddrReset;
      shifter      = '0;
      held_payload = '0;
      held_is_data = 1'b0;
      bus_to_idle();
      levels_due.delete();
      fail_count   = 0;
    end else begin
      if (cfg_wr_en)
        addr_byte = cfg_wr_data;
      if (out_ch.valid && out_ch.ready) begin
        got = '{scl_level: out_ch.scl_level, sda_level: out_ch.sda_level,
                busy_res: out_ch.busy_res, done_res: out_ch.done_res,
                nack_seen: out_ch.nack_seen};
        if (levels_due.size() == 0) begin
          report("result transaction with nothing expected");
        end else begin
          due = levels_due.pop_front();
          compare_field("scl_level", got.scl_level, due.scl_level);
          compare_field("sda_level", got.sda_level, due.sda_level);
          compare_field("busy_res", got.busy_res, due.busy_res);
          compare_field("done_res", got.done_res, due.done_res);
          compare_field("nack_seen", got.nack_seen, due.nack_seen);
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        it = '{req_type: in_ch.req_type, is_data: in_ch.is_data,
               payload: in_ch.payload, sda_sample: in_ch.sda_sample};
        levels_due.push_back(advance_bus(it));
      end
    end
    outstanding = levels_due.size();
  end

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 100ps
module tb;
  import idbw_pkg::*;

  localparam int CycleLimit    = 400000;
  localparam int SqueezeCycles = 300;
  localparam int RandomItems   = 500;

  logic       clk;
  logic       rst;
  logic       cfg_wr_en;
  logic [7:0] cfg_wr_data;

  int outstanding;
  int fail_count;
  int cycles       = 0;
  int items_sent   = 0;
  bit pace         = 1'b1;
  bit squeeze_req  = 1'b0;
  bit squeeze_done = 1'b0;

  idbw_in_if  in_ch();
  idbw_out_if out_ch();

  i2c_display_byte_writer dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_ch       (in_ch),
    .out_ch      (out_ch)
  );

  i2c_write_checker bus_check (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .outstanding (outstanding),
    .fail_count  (fail_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic put_item(in_item_t it);
    int g;
    g = pace ? gap_len() : 0;
    if (g > 0) begin
      in_ch.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.req_type   <= it.req_type;
    in_ch.is_data    <= it.is_data;
    in_ch.payload    <= it.payload;
    in_ch.sda_sample <= it.sda_sample;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    items_sent++;
  endtask

  // one send, then enough ticks for a full transfer plus a few ack repeats
  task automatic run_transfer(logic [7:0] byte_val, logic data_flag, int nack_pct,
                              int noise_pct);
    in_item_t it;
    int       n;
    it = '{req_type: ReqSend, is_data: data_flag, payload: byte_val,
           sda_sample: 1'($urandom)};
    put_item(it);
    n = 90 + $urandom_range(0, 12);
    repeat (n) begin
      it.req_type   = ($urandom_range(0, 99) < noise_pct) ? ReqSend : ReqTick;
      it.is_data    = 1'($urandom);
      it.payload    = 8'($urandom);
      it.sda_sample = ($urandom_range(0, 99) < nack_pct);
      put_item(it);
    end
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
    @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_address(logic [7:0] value);
    cfg_wr_data <= value;
    cfg_wr_en   <= 1'b1;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // receiver: random stalls, one long hold-off on request
  initial begin
    int g;
    out_ch.ready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (squeeze_req && !squeeze_done) begin
        squeeze_done = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (SqueezeCycles) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 40)) @(posedge clk);
      g = gap_len();
      if (g > 0) begin
        out_ch.ready <= 1'b0;
        repeat (g) @(posedge clk);
      end
    end
  end

  initial begin
    in_item_t it;
    int       target;
    rst              = 1'b1;
    cfg_wr_en        = 1'b0;
    cfg_wr_data      = 8'h00;
    in_ch.valid      = 1'b0;
    in_ch.req_type   = ReqTick;
    in_ch.is_data    = 1'b0;
    in_ch.payload    = 8'h00;
    in_ch.sda_sample = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // ticks while idle change nothing
    it = '{req_type: ReqTick, is_data: 1'b1, payload: 8'hFF, sda_sample: 1'b1};
    put_item(it);
    it = '{req_type: ReqTick, is_data: 1'b0, payload: 8'h00, sda_sample: 1'b0};
    put_item(it);

    // reset address, clean command transfer, then a data transfer with many nacks
    // and sends while busy
    run_transfer(8'h00, 1'b0, 0, 0);
    run_transfer(8'hFF, 1'b1, 50, 5);
    settle();
    write_address(8'h00);
    run_transfer(8'hA5, 1'b1, 0, 0);
    settle();
    write_address(8'hFF);
    run_transfer(8'h5A, 1'b0, 20, 3);

    target = RandomItems;
    while (items_sent < target) begin
      settle();
      case ($urandom_range(0, 3))
        0:       write_address(8'h00);
        1:       write_address(8'hFF);
        default: write_address(8'($urandom));
      endcase
      pace = ($urandom_range(0, 3) != 0);
      if (items_sent > target - RandomItems / 2)
        squeeze_req = 1'b1;
      repeat (2) run_transfer(8'($urandom), 1'($urandom), 10, 2);
    end

    settle();
    repeat (4) @(posedge clk);
    if (fail_count == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

@@ i2c_display_byte_writer.f @@
design/idbw_pkg.sv
design/idbw_in_if.sv
design/idbw_out_if.sv
design/i2c_display_byte_writer.sv
sim/i2c_write_checker.sv
sim/tb.sv
